// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the charge integrator.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/pcih_pkg.sv
// Types and constants for the pulse charge integrator histogram.
// No dependencies; used by the top level and the testbench.
`default_nettype none
package pcih_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MUL   = 13'b0000000000100,
        S_SUB   = 13'b0000000001000,
        S_DIV1  = 13'b0000000010000,
        S_CLASS = 13'b0000000100000,
        S_CMP   = 13'b0000001000000,
        S_LOAD2 = 13'b0000010000000,
        S_DIV2  = 13'b0000100000000,
        S_BIN   = 13'b0001000000000,
        S_UPD   = 13'b0010000000000,
        S_RDW   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EVENT_LENGTH    = 3'd0;
    localparam logic [2:0] CFG_BASELINE_LENGTH = 3'd1;
    localparam logic [2:0] CFG_RANGE_LOW       = 3'd2;
    localparam logic [2:0] CFG_RANGE_HIGH      = 3'd3;
    localparam logic [2:0] CFG_BINS_IN_USE     = 3'd4;

    // Commands and result kinds.
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_READ     = 1'b1;
    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // Range codes.
    localparam logic [1:0] CODE_IN    = 2'd0;
    localparam logic [1:0] CODE_UNDER = 2'd1;
    localparam logic [1:0] CODE_OVER  = 2'd2;

    // Special read addresses.
    localparam logic [9:0] READ_UNDER = 10'd512;
    localparam logic [9:0] READ_OVER  = 10'd513;

    // Field widths and limits.
    localparam int RANGE_W     = 25;
    localparam int CNT_W       = 32;
    localparam int INT_MAG_MAX = 16777215;

    // Register reset values.
    localparam logic [10:0] RST_EVENT_LENGTH    = 11'd500;
    localparam logic [10:0] RST_BASELINE_LENGTH = 11'd50;
    localparam logic signed [24:0] RST_RANGE_LOW  = 25'sd3000;
    localparam logic signed [24:0] RST_RANGE_HIGH = 25'sd600000;
    localparam logic [9:0] RST_BINS_IN_USE = 10'd500;

endpackage
`default_nettype wire

// File: src/pcih_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pcih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/pulse_charge_integrator_histogram_top.sv
// Top level of the pulse charge integrator with histogram.
// Depends on pcih_pkg, pcih_ram and assert_macros.svh.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_command, i_sample, i_read_bin
//  result    out        o_out_valid / i_out_ready  o_result_kind ... o_max_integral
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A sample that does not end an event leaves the input ready. An in-range event
// end closes the input for two passes of the shift-subtract divider (DW quotient
// bits each) plus the sequencing states MUL, SUB, CLASS, CMP, LOAD2, BIN, UPD and
// EMIT. An underflow or overflow event skips the second pass. A stored bin read
// passes through a memory read state first; a counter read goes straight to EMIT.
// After reset a clearing pass writes zero to all MAX_BINS bin counts, one per
// cycle, before the first item is taken. A stalled result holds the sequencer.
`default_nettype none
`include "assert_macros.svh"
module pulse_charge_integrator_histogram_top #(
    parameter int MAX_BINS          = 512,
    parameter int MAX_EVENT_SAMPLES = 1024,
    parameter int SAMPLE_BITS       = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_command,
    input  wire logic [13:0]        i_sample,
    input  wire logic [9:0]         i_read_bin,
    // Result channel
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic               o_result_kind,
    output      logic signed [24:0] o_integral,
    output      logic [8:0]         o_bin_index,
    output      logic [1:0]         o_range_code,
    output      logic [31:0]        o_bin_count,
    output      logic [31:0]        o_events_seen,
    output      logic signed [24:0] o_min_integral,
    output      logic signed [24:0] o_max_integral,
    // Configuration port
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [24:0]        i_cfg_data
);

    localparam int LW    = $clog2(MAX_EVENT_SAMPLES + 1);
    localparam int POS_W = $clog2(MAX_EVENT_SAMPLES);
    localparam int SW    = SAMPLE_BITS + LW;
    localparam int PW    = LW + SW;
    localparam int BW    = $clog2(MAX_BINS + 1);
    localparam int AW    = $clog2(MAX_BINS);
    localparam int VW    = pcih_pkg::RANGE_W;
    localparam int DW    = (PW > VW + BW) ? PW : VW + BW;
    localparam int CW    = $clog2(DW + 1);
    localparam int SIN_W = (SAMPLE_BITS < 14) ? SAMPLE_BITS : 14;

    // Configuration registers.
    logic [10:0]        r_event_length;
    logic [10:0]        r_baseline_length;
    logic signed [24:0] r_range_low;
    logic signed [24:0] r_range_high;
    logic [9:0]         r_bins_in_use;

    // Control and state registers.
    pcih_pkg::t_state   r_state;
    logic [AW-1:0]      r_clr;
    logic [POS_W-1:0]   r_pos;
    logic [SW-1:0]      r_bsum;
    logic [SW-1:0]      r_esum;
    logic [LW-1:0]      r_n;
    logic [LW-1:0]      r_b;
    logic [PW-1:0]      r_p1;
    logic [PW-1:0]      r_p2;
    logic               r_neg;
    logic [DW-1:0]      r_q;
    logic [VW:0]        r_rem;
    logic [VW-1:0]      r_div;
    logic [CW-1:0]      r_cnt;
    logic signed [24:0] r_integral;
    logic [BW-1:0]      r_nb;
    logic [VW+BW-1:0]   r_prod2;
    logic [AW-1:0]      r_bin;
    logic [31:0]        r_under;
    logic [31:0]        r_over;
    logic [31:0]        r_events;
    logic signed [24:0] r_min;
    logic signed [24:0] r_max;
    logic               r_out_valid;

    // Staged result fields.
    logic               r_st_kind;
    logic signed [24:0] r_st_int;
    logic [AW-1:0]      r_st_bin;
    logic [1:0]         r_st_code;
    logic [31:0]        r_st_cnt;

    // Effective lengths in force for the current sample.
    logic [LW-1:0]      eff_n;
    logic [LW-1:0]      eff_b;
    logic [10:0]        b_nz;
    logic [SW-1:0]      sample_v;
    logic [SW-1:0]      bsum_nx;
    logic [SW-1:0]      esum_nx;
    logic               is_last;

    always_comb begin
        if (r_event_length == '0) begin
            eff_n = LW'(1);
        end else if (32'(r_event_length) > MAX_EVENT_SAMPLES) begin
            eff_n = LW'(MAX_EVENT_SAMPLES);
        end else begin
            eff_n = LW'(r_event_length);
        end
        b_nz = (r_baseline_length == '0) ? 11'd1 : r_baseline_length;
        if (32'(b_nz) > 32'(eff_n)) begin
            eff_b = eff_n;
        end else begin
            eff_b = LW'(b_nz);
        end
        sample_v = SW'(i_sample[SIN_W-1:0]);
        bsum_nx  = (32'(r_pos) < 32'(eff_b)) ? r_bsum + sample_v : r_bsum;
        esum_nx  = r_esum + sample_v;
        is_last  = (32'(r_pos) + 32'd1) >= 32'(eff_n);
    end

    // Shift-subtract divider step shared by both divisions.
    logic [VW:0] rem_sh;
    logic        q_bit;
    always_comb begin
        rem_sh = {r_rem[VW-1:0], r_q[DW-1]};
        q_bit  = rem_sh >= {1'b0, r_div};
    end

    // Signed difference of the two products.
    logic          num_neg;
    logic [PW-1:0] num_mag;
    assign num_neg = r_p1 < r_p2;
    assign num_mag = num_neg ? r_p2 - r_p1 : r_p1 - r_p2;

    // Saturated, signed integral from the first quotient.
    logic [23:0]        int_mag;
    logic signed [24:0] int_val;
    always_comb begin
        int_mag = (r_q > DW'(pcih_pkg::INT_MAG_MAX)) ? 24'hFFFFFF : r_q[23:0];
        int_val = r_neg ? -$signed({1'b0, int_mag}) : $signed({1'b0, int_mag});
    end

    // Range classification of the integral.
    logic signed [25:0] diff;
    logic signed [25:0] span;
    logic               is_under;
    logic               is_over;
    logic [BW-1:0]      nb_eff;
    always_comb begin
        diff     = 26'(r_integral) - 26'(r_range_low);
        span     = 26'(r_range_high) - 26'(r_range_low);
        is_under = r_integral < r_range_low;
        is_over  = r_integral >= r_range_high;
        if (r_bins_in_use == '0) begin
            nb_eff = BW'(1);
        end else if (32'(r_bins_in_use) > MAX_BINS) begin
            nb_eff = BW'(MAX_BINS);
        end else begin
            nb_eff = BW'(r_bins_in_use);
        end
    end

    // Bin index from the second quotient, clamped below the bin count.
    logic [AW-1:0] bin_clamp;
    always_comb begin
        if (r_q >= DW'(r_nb)) begin
            bin_clamp = AW'(r_nb - BW'(1));
        end else begin
            bin_clamp = AW'(r_q);
        end
    end

    // Read address decode.
    logic [31:0]   rb_ext;
    logic          rb_stored;
    assign rb_ext    = 32'(i_read_bin);
    assign rb_stored = (rb_ext < 32'd512) && (rb_ext < MAX_BINS);

    // Bin count memory.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       ram_inc;

    assign ram_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_bin;
        ram_wdata = ram_inc;
        if (r_state == pcih_pkg::S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == pcih_pkg::S_UPD) begin
            ram_we    = 1'b1;
        end
        ram_raddr = (r_state == pcih_pkg::S_BIN) ? bin_clamp : rb_ext[AW-1:0];
    end

    pcih_ram #(
        .WIDTH (pcih_pkg::CNT_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = r_state == pcih_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_length    <= pcih_pkg::RST_EVENT_LENGTH;
            r_baseline_length <= pcih_pkg::RST_BASELINE_LENGTH;
            r_range_low       <= pcih_pkg::RST_RANGE_LOW;
            r_range_high      <= pcih_pkg::RST_RANGE_HIGH;
            r_bins_in_use     <= pcih_pkg::RST_BINS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcih_pkg::CFG_EVENT_LENGTH:    r_event_length    <= i_cfg_data[10:0];
                pcih_pkg::CFG_BASELINE_LENGTH: r_baseline_length <= i_cfg_data[10:0];
                pcih_pkg::CFG_RANGE_LOW:       r_range_low       <= $signed(i_cfg_data);
                pcih_pkg::CFG_RANGE_HIGH:      r_range_high      <= $signed(i_cfg_data);
                pcih_pkg::CFG_BINS_IN_USE:     r_bins_in_use     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: accumulation, divisions, classification and memory update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcih_pkg::S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_bsum      <= '0;
            r_esum      <= '0;
            r_cnt       <= '0;
            r_under     <= '0;
            r_over      <= '0;
            r_events    <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output state handles its own valid flag when it reloads.
            if (r_out_valid && i_out_ready && r_state != pcih_pkg::S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pcih_pkg::S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == MAX_BINS - 1) begin
                        r_state <= pcih_pkg::S_IDLE;
                    end
                end
                pcih_pkg::S_IDLE: begin
                    if (in_acc && i_command == pcih_pkg::CMD_READ) begin
                        r_st_kind <= pcih_pkg::KIND_READ;
                        r_st_int  <= '0;
                        r_st_bin  <= '0;
                        r_st_code <= pcih_pkg::CODE_IN;
                        r_st_cnt  <= '0;
                        if (rb_stored) begin
                            r_state <= pcih_pkg::S_RDW;
                        end else begin
                            if (i_read_bin == pcih_pkg::READ_UNDER) begin
                                r_st_code <= pcih_pkg::CODE_UNDER;
                                r_st_cnt  <= r_under;
                            end else if (i_read_bin == pcih_pkg::READ_OVER) begin
                                r_st_code <= pcih_pkg::CODE_OVER;
                                r_st_cnt  <= r_over;
                            end
                            r_state <= pcih_pkg::S_EMIT;
                        end
                    end else if (in_acc) begin
                        r_bsum <= bsum_nx;
                        r_esum <= esum_nx;
                        if (is_last) begin
                            r_pos   <= '0;
                            r_n     <= eff_n;
                            r_b     <= eff_b;
                            r_state <= pcih_pkg::S_MUL;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                        end
                    end
                end
                pcih_pkg::S_MUL: begin
                    r_p1    <= PW'(r_n) * PW'(r_bsum);
                    r_p2    <= PW'(r_b) * PW'(r_esum);
                    r_bsum  <= '0;
                    r_esum  <= '0;
                    r_state <= pcih_pkg::S_SUB;
                end
                pcih_pkg::S_SUB: begin
                    r_neg   <= num_neg;
                    r_q     <= DW'(num_mag);
                    r_rem   <= '0;
                    r_div   <= VW'(r_b);
                    r_cnt   <= CW'(DW);
                    r_state <= pcih_pkg::S_DIV1;
                end
                pcih_pkg::S_DIV1, pcih_pkg::S_DIV2: begin
                    r_rem <= q_bit ? rem_sh - {1'b0, r_div} : rem_sh;
                    r_q   <= {r_q[DW-2:0], q_bit};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= (r_state == pcih_pkg::S_DIV1) ? pcih_pkg::S_CLASS
                                                                 : pcih_pkg::S_BIN;
                    end
                end
                pcih_pkg::S_CLASS: begin
                    r_integral <= int_val;
                    r_state    <= pcih_pkg::S_CMP;
                end
                pcih_pkg::S_CMP: begin
                    // Statistics over all events.
                    if (r_events == '0) begin
                        r_min <= r_integral;
                        r_max <= r_integral;
                    end else begin
                        if (r_integral < r_min) begin
                            r_min <= r_integral;
                        end
                        if (r_integral > r_max) begin
                            r_max <= r_integral;
                        end
                    end
                    if (r_events != '1) begin
                        r_events <= r_events + 32'd1;
                    end
                    r_st_kind <= pcih_pkg::KIND_EVENT;
                    r_st_int  <= r_integral;
                    r_st_bin  <= '0;
                    if (is_under) begin
                        r_st_code <= pcih_pkg::CODE_UNDER;
                        r_under   <= (r_under == '1) ? r_under : r_under + 32'd1;
                        r_st_cnt  <= (r_under == '1) ? r_under : r_under + 32'd1;
                        r_state   <= pcih_pkg::S_EMIT;
                    end else if (is_over) begin
                        r_st_code <= pcih_pkg::CODE_OVER;
                        r_over    <= (r_over == '1) ? r_over : r_over + 32'd1;
                        r_st_cnt  <= (r_over == '1) ? r_over : r_over + 32'd1;
                        r_state   <= pcih_pkg::S_EMIT;
                    end else begin
                        r_st_code <= pcih_pkg::CODE_IN;
                        r_nb      <= nb_eff;
                        r_prod2   <= (VW + BW)'(diff[VW-1:0]) * (VW + BW)'(nb_eff);
                        r_state   <= pcih_pkg::S_LOAD2;
                    end
                end
                pcih_pkg::S_LOAD2: begin
                    r_q     <= DW'(r_prod2);
                    r_rem   <= '0;
                    r_div   <= span[VW-1:0];
                    r_cnt   <= CW'(DW);
                    r_state <= pcih_pkg::S_DIV2;
                end
                pcih_pkg::S_BIN: begin
                    r_bin    <= bin_clamp;
                    r_st_bin <= bin_clamp;
                    r_state  <= pcih_pkg::S_UPD;
                end
                pcih_pkg::S_UPD: begin
                    r_st_cnt <= ram_inc;
                    r_state  <= pcih_pkg::S_EMIT;
                end
                pcih_pkg::S_RDW: begin
                    r_st_cnt <= ram_rdata;
                    r_state  <= pcih_pkg::S_EMIT;
                end
                pcih_pkg::S_EMIT: begin
                    // Load the output register once it is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        o_result_kind  <= r_st_kind;
                        o_integral     <= r_st_int;
                        o_bin_index    <= 9'(32'(r_st_bin));
                        o_range_code   <= r_st_code;
                        o_bin_count    <= r_st_cnt;
                        o_events_seen  <= r_events;
                        o_min_integral <= r_min;
                        o_max_integral <= r_max;
                        r_state        <= pcih_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= pcih_pkg::S_IDLE;
                end
            endcase
        end
    end

    // No item is taken while the bin memory is being cleared.
    `ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n,
                r_state == pcih_pkg::S_CLEAR, !o_in_ready)
    // The bin memory is written only by the clearing pass or a bin update.
    `ASSERT_IMP(a_ram_write_src, i_clk, i_rst_n, ram_we,
                r_state == pcih_pkg::S_CLEAR || r_state == pcih_pkg::S_UPD)
    // An event result always carries consistent extremes.
    `ASSERT_IMP(a_minmax_order, i_clk, i_rst_n,
                o_out_valid && o_result_kind == pcih_pkg::KIND_EVENT,
                o_min_integral <= o_max_integral && o_events_seen != '0)
    // A bin update always hands its result to the output stage next.
    `ASSERT_NXT(a_upd_to_emit, i_clk, i_rst_n,
                r_state == pcih_pkg::S_UPD, r_state == pcih_pkg::S_EMIT)

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the pulse charge integrator histogram.
// Depends on pcih_pkg and pulse_charge_integrator_histogram_top; it predicts every result
// with its own model of events, histogram and extremes and checks the result stream.
`timescale 1ns / 100ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HIST_BINS      = 512;
    localparam int EVENT_MAX      = 1024;

    typedef struct packed {
        logic               kind;
        logic signed [24:0] integral;
        logic [8:0]         bin;
        logic [1:0]         code;
        logic [31:0]        cnt;
        logic [31:0]        events;
        logic signed [24:0] lowest;
        logic signed [24:0] highest;
    } t_charge_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic               i_command    = pcih_pkg::CMD_SAMPLE;
    logic [13:0]        i_sample     = '0;
    logic [9:0]         i_read_bin   = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic               o_result_kind;
    logic signed [24:0] o_integral;
    logic [8:0]         o_bin_index;
    logic [1:0]         o_range_code;
    logic [31:0]        o_bin_count;
    logic [31:0]        o_events_seen;
    logic signed [24:0] o_min_integral;
    logic signed [24:0] o_max_integral;
    logic               i_cfg_we     = 1'b0;
    logic [2:0]         i_cfg_idx    = '0;
    logic [24:0]        i_cfg_data   = '0;

    pulse_charge_integrator_histogram_top i_dut (
        .i_clk, .i_rst_n,
        .i_in_valid, .o_in_ready, .i_command, .i_sample, .i_read_bin,
        .o_out_valid, .i_out_ready, .o_result_kind, .o_integral, .o_bin_index,
        .o_range_code, .o_bin_count, .o_events_seen, .o_min_integral, .o_max_integral,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the registers and of the block's state.
    int unsigned   reg_event_len, reg_base_len, reg_bins;
    longint        reg_low, reg_high;
    int unsigned   pos;
    longint        base_sum, event_sum;
    logic [31:0]   hist [HIST_BINS];
    logic [31:0]   under_cnt, over_cnt, event_cnt;
    longint        lowest_seen, highest_seen;

    t_charge_result expected_results [$];
    int            error_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_left      = 0;
    int            idle_cycles    = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // Register write as the block sees it, mirrored in the shadow registers.
    function automatic void shadow_reg(logic [2:0] idx, logic [24:0] data);
        case (idx)
            pcih_pkg::CFG_EVENT_LENGTH:    reg_event_len = data[10:0];
            pcih_pkg::CFG_BASELINE_LENGTH: reg_base_len  = data[10:0];
            pcih_pkg::CFG_RANGE_LOW:       reg_low       = longint'($signed(data));
            pcih_pkg::CFG_RANGE_HIGH:      reg_high      = longint'($signed(data));
            pcih_pkg::CFG_BINS_IN_USE:     reg_bins      = data[9:0];
            default: ;
        endcase
    endfunction

    // Work out the result, if any, that one accepted item causes.
    function automatic bit integrate_item(logic cmd, logic [13:0] s, logic [9:0] rb,
                                          output t_charge_result r);
        int unsigned n, b, nb, bin;
        longint      integ;
        r = '0;
        if (cmd == pcih_pkg::CMD_READ) begin
            r.kind = pcih_pkg::KIND_READ;
            r.code = pcih_pkg::CODE_IN;
            if (rb < HIST_BINS) begin
                r.cnt = hist[rb];
            end else if (rb == pcih_pkg::READ_UNDER) begin
                r.cnt = under_cnt;
                r.code = pcih_pkg::CODE_UNDER;
            end else if (rb == pcih_pkg::READ_OVER) begin
                r.cnt = over_cnt;
                r.code = pcih_pkg::CODE_OVER;
            end
        end else begin
            n = (reg_event_len == 0) ? 1 : reg_event_len;
            if (n > EVENT_MAX) n = EVENT_MAX;
            b = (reg_base_len == 0) ? 1 : reg_base_len;
            if (b > n) b = n;
            if (pos < b) base_sum += s;
            event_sum += s;
            if (pos + 1 < n) begin
                pos++;
                return 1'b0;
            end
            integ = (longint'(n) * base_sum - longint'(b) * event_sum) / longint'(b);
            if (integ > pcih_pkg::INT_MAG_MAX) integ = pcih_pkg::INT_MAG_MAX;
            if (integ < -pcih_pkg::INT_MAG_MAX) integ = -pcih_pkg::INT_MAG_MAX;
            pos = 0;
            base_sum = 0;
            event_sum = 0;
            bin = 0;
            if (integ < reg_low) begin
                r.code = pcih_pkg::CODE_UNDER;
                under_cnt = sat_inc(under_cnt);
                r.cnt = under_cnt;
            end else if (integ >= reg_high) begin
                r.code = pcih_pkg::CODE_OVER;
                over_cnt = sat_inc(over_cnt);
                r.cnt = over_cnt;
            end else begin
                nb = (reg_bins == 0) ? 1 : reg_bins;
                if (nb > HIST_BINS) nb = HIST_BINS;
                bin = int'(((integ - reg_low) * longint'(nb)) / (reg_high - reg_low));
                if (bin >= nb) bin = nb - 1;
                r.code = pcih_pkg::CODE_IN;
                hist[bin] = sat_inc(hist[bin]);
                r.cnt = hist[bin];
            end
            if (event_cnt == 0) begin
                lowest_seen = integ;
                highest_seen = integ;
            end else begin
                if (integ < lowest_seen) lowest_seen = integ;
                if (integ > highest_seen) highest_seen = integ;
            end
            event_cnt = sat_inc(event_cnt);
            r.kind = pcih_pkg::KIND_EVENT;
            r.integral = integ[24:0];
            r.bin = bin[8:0];
        end
        r.events = event_cnt;
        r.lowest = lowest_seen[24:0];
        r.highest = highest_seen[24:0];
        return 1'b1;
    endfunction

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker against the oldest expected result.
    always @(posedge i_clk) begin
        t_charge_result act, exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            act = '{o_result_kind, o_integral, o_bin_index, o_range_code, o_bin_count,
                    o_events_seen, o_min_integral, o_max_integral};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d integral=%0d", $realtime,
                         act.kind, act.integral);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (act !== exp_r) begin
                    $display("%0t: mismatch expected kind=%0d int=%0d bin=%0d code=%0d",
                             $realtime, exp_r.kind, exp_r.integral, exp_r.bin, exp_r.code);
                    $display("%0t:          expected cnt=%0d ev=%0d min=%0d max=%0d",
                             $realtime, exp_r.cnt, exp_r.events, exp_r.lowest,
                             exp_r.highest);
                    $display("%0t:          actual   kind=%0d int=%0d bin=%0d code=%0d",
                             $realtime, act.kind, act.integral, act.bin, act.code);
                    $display("%0t:          actual   cnt=%0d ev=%0d min=%0d max=%0d",
                             $realtime, act.cnt, act.events, act.lowest, act.highest);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, wait for its acceptance and record what it should cause.
    // Called and returns at a falling edge; valid is left high for the next item.
    task automatic send_item(logic cmd, logic [13:0] s, logic [9:0] rb);
        t_charge_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command = cmd;
        i_sample = s;
        i_read_bin = rb;
        do @(posedge i_clk); while (!o_in_ready);
        if (integrate_item(cmd, s, rb, r)) begin
            expected_results.insert(expected_results.size(), r);
        end
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected result and let the block settle.
    task automatic drain;
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value[24:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow_reg(idx, value[24:0]);
    endtask

    task automatic set_config(int ev, int bl, longint lo, longint hi, int nb);
        drain();
        write_reg(pcih_pkg::CFG_EVENT_LENGTH, ev);
        write_reg(pcih_pkg::CFG_BASELINE_LENGTH, bl);
        write_reg(pcih_pkg::CFG_RANGE_LOW, lo);
        write_reg(pcih_pkg::CFG_RANGE_HIGH, hi);
        write_reg(pcih_pkg::CFG_BINS_IN_USE, nb);
    endtask

    // Reads right after reset, including the counters and unused addresses.
    task automatic test_reads_after_reset;
        send_item(pcih_pkg::CMD_READ, '0, 10'd0);
        send_item(pcih_pkg::CMD_READ, '1, 10'd511);
        send_item(pcih_pkg::CMD_READ, '0, pcih_pkg::READ_UNDER);
        send_item(pcih_pkg::CMD_READ, '0, pcih_pkg::READ_OVER);
        send_item(pcih_pkg::CMD_READ, '0, 10'd1023);
    endtask

    // Short events at the sample extremes, clamped lengths and bins.
    task automatic test_short_events;
        set_config(4, 2000, -100000, 100000, 1023);
        send_item(pcih_pkg::CMD_SAMPLE, 14'd0, '0);
        repeat (3) send_item(pcih_pkg::CMD_SAMPLE, 14'h3FFF, '0);
        set_config(4, 1, -100000, 100000, 512);
        send_item(pcih_pkg::CMD_SAMPLE, 14'h3FFF, '0);
        repeat (3) send_item(pcih_pkg::CMD_SAMPLE, 14'd0, '0);
        // Zero lengths and zero bins are taken as one.
        set_config(0, 0, -16777215, 16777215, 0);
        send_item(pcih_pkg::CMD_SAMPLE, 14'h2AAA, '0);
        send_item(pcih_pkg::CMD_SAMPLE, 14'h1555, '0);
        // Inverted range: everything at or above the low edge overflows.
        set_config(3, 1, 10, -10, 1);
        send_item(pcih_pkg::CMD_SAMPLE, 14'd100, 10'h3FF);
        send_item(pcih_pkg::CMD_SAMPLE, 14'd0, '0);
        send_item(pcih_pkg::CMD_SAMPLE, 14'd0, '0);
        send_item(pcih_pkg::CMD_READ, '0, pcih_pkg::READ_OVER);
        send_item(pcih_pkg::CMD_READ, '0, pcih_pkg::READ_UNDER);
        send_item(pcih_pkg::CMD_READ, '0, 10'd0);
    endtask

    // One event at the longest length, baseline as long as the event.
    task automatic test_longest_event;
        set_config(2047, 1024, -16777215, 16777215, 512);
        for (int k = 0; k < EVENT_MAX; k++) begin
            send_item(pcih_pkg::CMD_SAMPLE, 14'($urandom_range(16383)), '0);
        end
        send_item(pcih_pkg::CMD_READ, '0, 10'd256);
    endtask

    // Random events with random registers under one idling pattern.
    task automatic test_random_phase(int items, int s_pct, int r_pct, int hold);
        int     ev, bl, nb, level, rb;
        longint span, lo, hi;
        ev = ($urandom_range(15) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
        bl = $urandom_range(ev + 2);
        nb = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(512, 1);
        span = 16383 * longint'(ev);
        lo = longint'($urandom_range(32'(span + span / 4))) - span;
        if ($urandom_range(7) == 0) hi = lo - longint'($urandom_range(1000));
        else hi = lo + 1 + longint'($urandom_range(32'(2 * span)));
        if (hi > pcih_pkg::INT_MAG_MAX) hi = pcih_pkg::INT_MAG_MAX;
        if (hi < -pcih_pkg::INT_MAG_MAX) hi = -pcih_pkg::INT_MAG_MAX;
        set_config(ev, bl, lo, hi, nb);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        hold_left = hold;
        level = $urandom_range(16383);
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0: rb = $urandom_range(1023);
                    1: rb = $urandom_range(1) ? pcih_pkg::READ_UNDER : pcih_pkg::READ_OVER;
                    default: rb = $urandom_range(511);
                endcase
                send_item(pcih_pkg::CMD_READ, 14'($urandom), 10'(rb));
            end else if ($urandom_range(1)) begin
                send_item(pcih_pkg::CMD_SAMPLE, 14'($urandom_range(16383)), 10'($urandom));
            end else begin
                // Pulse-like samples around a baseline level.
                send_item(pcih_pkg::CMD_SAMPLE,
                          14'((level + $urandom_range(255)) & 16'h3FFF),
                          10'($urandom));
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        reg_event_len = pcih_pkg::RST_EVENT_LENGTH;
        reg_base_len = pcih_pkg::RST_BASELINE_LENGTH;
        reg_low = pcih_pkg::RST_RANGE_LOW;
        reg_high = pcih_pkg::RST_RANGE_HIGH;
        reg_bins = pcih_pkg::RST_BINS_IN_USE;
        pos = 0;
        base_sum = 0;
        event_sum = 0;
        foreach (hist[k]) hist[k] = '0;
        under_cnt = '0;
        over_cnt = '0;
        event_cnt = '0;
        lowest_seen = 0;
        highest_seen = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reads_after_reset();
        test_short_events();
        test_longest_event();
        test_random_phase(70, 0, 0, 0);
        test_random_phase(70, 62, 0, 0);
        test_random_phase(70, 0, 62, 0);
        test_random_phase(70, 13, 13, 0);
        test_random_phase(70, 0, 0, 600);
        drain();

        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
